// ===== rtl/lvss_pkg.sv =====
package lvss_pkg;

  // image geometry
  localparam int MAX_DIM   = 1024;
  localparam int COL_W     = 10;
  localparam int POS_W     = 11;
  localparam int KERNEL    = 15;
  localparam int WIN       = KERNEL + 1;
  localparam int RADIUS    = KERNEL / 2;
  localparam int GAIN_FRAC = 16;

  // accumulator widths, sums wrap at these sizes
  localparam int CS_W  = 12;
  localparam int CQ_W  = 20;
  localparam int WS_W  = 16;
  localparam int WQ_W  = 24;
  localparam int NUM_W = 9;

  // shared divider
  localparam int DIV_N_W = 40;
  localparam int DIV_D_W = 26;

  // skin thresholds
  localparam logic [7:0] SKIN_Y_MIN = 8'd80;
  localparam logic [7:0] SKIN_CB_LO = 8'd85;
  localparam logic [7:0] SKIN_CB_HI = 8'd135;
  localparam logic [7:0] SKIN_CR_LO = 8'd135;
  localparam logic [7:0] SKIN_CR_HI = 8'd180;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_NOISE_VARIANCE = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_UPD
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ,
    B_T_GO,
    B_T_WAIT,
    B_M_GO,
    B_M_WAIT,
    B_DEN,
    B_G_GO,
    B_G_WAIT,
    B_MUL,
    B_SUM,
    B_OUT
  } back_state_t;

  // one column entry: per channel sum and sum of squares
  typedef struct packed {
    logic [2:0][CS_W-1:0] cs;
    logic [2:0][CQ_W-1:0] cq;
  } colsum_t;

  // work handed from front to back
  typedef struct packed {
    logic [2:0][WS_W-1:0] s;
    logic [2:0][WQ_W-1:0] q;
    logic [NUM_W-1:0]     num;
    logic [2:0][7:0]      pix;
    logic                 skin;
    logic [COL_W-1:0]     cx;
    logic [COL_W-1:0]     cy;
    logic                 last;
  } lvss_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lvss_qstat_t;

endpackage

// ===== rtl/lvss_div.sv =====
module lvss_div import lvss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  logic               busy;
  logic [5:0]         cnt;
  logic [DIV_D_W:0]   rem;
  logic [DIV_D_W-1:0] dsr;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem[DIV_D_W-1:0], quotient[DIV_N_W-1]};
    fits   = rem_sh >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
      quotient <= {quotient[DIV_N_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/lvss_fifo.sv =====
module lvss_fifo import lvss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  lvss_job_t   wr_job,
  input  logic        rd,
  output lvss_job_t   rd_job,
  output lvss_qstat_t qstat
);

  lvss_job_t          slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign rd_job      = slots[rptr];
  assign qstat.full  = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign qstat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wr_job;
  end

endmodule

// ===== rtl/lvss_front.sv =====
module lvss_front import lvss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [POS_W-1:0] image_width,
  input  logic [POS_W-1:0] image_height,
  input  logic             push,
  output logic             full,
  input  logic             first_of_frame,
  input  logic [7:0]       blue,
  input  logic [7:0]       green,
  input  logic [7:0]       red,
  input  logic [7:0]       luma,
  input  logic [7:0]       chroma_red,
  input  logic [7:0]       chroma_blue,
  input  lvss_qstat_t      qstat,
  output logic             job_push,
  output lvss_job_t        job
);

  localparam int RS_AW = COL_W + 4;

  front_state_t fstate, fstate_next;

  logic [47:0]   row_mem [WIN*MAX_DIM];
  colsum_t       col_mem [MAX_DIM];

  logic [COL_W-1:0] clr_cnt;
  logic [POS_W-1:0] row_pos, col_pos;
  logic [POS_W-1:0] cur_row, cur_col;
  logic [47:0]      cur_pix;
  colsum_t          col_rd;
  logic [47:0]      old_rd, ctr_rd;
  logic [2:0][WS_W-1:0] win_s;
  logic [2:0][WQ_W-1:0] win_q;
  colsum_t          taps [WIN];

  logic [POS_W-1:0] w, h;
  logic             accept;
  logic [POS_W-1:0] eff_row, eff_col, cy_e, cx_e;
  logic [POS_W:0]   nxt_col, nxt_row;
  logic [POS_W-1:0] row_adv, col_adv;

  colsum_t              cs_new;
  logic [2:0][WS_W-1:0] ws_new;
  logic [2:0][WQ_W-1:0] wq_new;
  logic                 col_in, row_in, sub_en, out_cond;
  logic [POS_W:0]       x2, y2, x1, y1, dx, dy;
  logic [POS_W-1:0]     cy, cx;
  logic [7:0]           old_b, new_b;
  logic [7:0]           cy_y, cy_cr, cy_cb;

  // clamp sizes to 1..MAX_DIM
  always_comb begin
    w = image_width;
    if (image_width == '0) w = POS_W'(1);
    else if (image_width > POS_W'(MAX_DIM)) w = POS_W'(MAX_DIM);
    h = image_height;
    if (image_height == '0) h = POS_W'(1);
    else if (image_height > POS_W'(MAX_DIM)) h = POS_W'(MAX_DIM);
  end

  always_comb begin
    case (fstate)
      F_CLEAR: fstate_next = (clr_cnt == COL_W'(MAX_DIM - 1)) ? F_IDLE : F_CLEAR;
      F_IDLE:  fstate_next = accept ? F_UPD : F_IDLE;
      F_UPD:   fstate_next = F_IDLE;
      default: fstate_next = F_CLEAR;
    endcase
  end

  always_comb begin
    full     = !(fstate == F_IDLE && !qstat.full);
    accept   = push && !full;
    job_push = (fstate == F_UPD) && out_cond;
  end

  // position of the arriving item and where the counters go next
  always_comb begin
    eff_row = first_of_frame ? '0 : row_pos;
    eff_col = first_of_frame ? '0 : col_pos;
    cy_e    = eff_row - POS_W'(RADIUS);
    cx_e    = eff_col - POS_W'(RADIUS);
    nxt_col = {1'b0, eff_col} + 1'b1;
    nxt_row = {1'b0, eff_row} + 1'b1;
    col_adv = nxt_col[POS_W-1:0];
    row_adv = eff_row;
    if (nxt_col >= {1'b0, w} + (POS_W+1)'(RADIUS)) begin
      col_adv = '0;
      row_adv = nxt_row[POS_W-1:0];
      if (nxt_row >= {1'b0, h} + (POS_W+1)'(RADIUS)) row_adv = '0;
    end
  end

  // column and window update
  always_comb begin
    col_in = cur_col < w;
    row_in = cur_row < h;
    sub_en = (cur_col >= POS_W'(WIN)) && ((cur_col - POS_W'(WIN)) < w);
    for (int c = 0; c < 3; c++) begin
      old_b = old_rd[8*c +: 8];
      new_b = cur_pix[8*c +: 8];
      cs_new.cs[c] = (cur_row == '0) ? '0 : col_rd.cs[c];
      cs_new.cq[c] = (cur_row == '0) ? '0 : col_rd.cq[c];
      if (cur_row >= POS_W'(WIN)) begin
        cs_new.cs[c] = cs_new.cs[c] - CS_W'(old_b);
        cs_new.cq[c] = cs_new.cq[c] - CQ_W'(old_b * old_b);
      end
      if (row_in) begin
        cs_new.cs[c] = cs_new.cs[c] + CS_W'(new_b);
        cs_new.cq[c] = cs_new.cq[c] + CQ_W'(new_b * new_b);
      end
      ws_new[c] = (cur_col == '0) ? '0 : win_s[c];
      wq_new[c] = (cur_col == '0) ? '0 : win_q[c];
      if (col_in) begin
        ws_new[c] = ws_new[c] + WS_W'(cs_new.cs[c]);
        wq_new[c] = wq_new[c] + WQ_W'(cs_new.cq[c]);
      end
      if (sub_en) begin
        ws_new[c] = ws_new[c] - WS_W'(taps[WIN-1].cs[c]);
        wq_new[c] = wq_new[c] - WQ_W'(taps[WIN-1].cq[c]);
      end
    end
  end

  // centre pixel, window area and skin test
  always_comb begin
    out_cond = (cur_row >= POS_W'(RADIUS)) && (cur_col >= POS_W'(RADIUS)) &&
               ((cur_row - POS_W'(RADIUS)) < h) && ((cur_col - POS_W'(RADIUS)) < w);
    cy = cur_row - POS_W'(RADIUS);
    cx = cur_col - POS_W'(RADIUS);
    x2 = ({1'b0, cur_col} + 1'b1 > {1'b0, w}) ? {1'b0, w} : {1'b0, cur_col} + 1'b1;
    y2 = ({1'b0, cur_row} + 1'b1 > {1'b0, h}) ? {1'b0, h} : {1'b0, cur_row} + 1'b1;
    x1 = (cur_col >= POS_W'(KERNEL)) ? {1'b0, cur_col - POS_W'(KERNEL)} : '0;
    y1 = (cur_row >= POS_W'(KERNEL)) ? {1'b0, cur_row - POS_W'(KERNEL)} : '0;
    dx = x2 - x1;
    dy = y2 - y1;
    cy_y  = ctr_rd[31:24];
    cy_cr = ctr_rd[39:32];
    cy_cb = ctr_rd[47:40];
    job.s    = ws_new;
    job.q    = wq_new;
    job.num  = NUM_W'(dx[4:0] * dy[4:0]);
    job.pix  = ctr_rd[23:0];
    job.skin = (cy_y > SKIN_Y_MIN) && (cy_cb > SKIN_CB_LO) && (cy_cb < SKIN_CB_HI) &&
               (cy_cr > SKIN_CR_LO) && (cy_cr < SKIN_CR_HI);
    job.cx   = cx[COL_W-1:0];
    job.cy   = cy[COL_W-1:0];
    job.last = (cy == h - 1'b1) && (cx == w - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate  <= F_CLEAR;
      clr_cnt <= '0;
      row_pos <= '0;
      col_pos <= '0;
    end else begin
      fstate <= fstate_next;
      if (fstate == F_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (accept) begin
        row_pos <= row_adv;
        col_pos <= col_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_row <= eff_row;
      cur_col <= eff_col;
      cur_pix <= {chroma_blue, chroma_red, luma, red, green, blue};
    end
    if (fstate == F_UPD) begin
      win_s   <= ws_new;
      win_q   <= wq_new;
      taps[0] <= col_in ? cs_new : '0;
      for (int i = 1; i < WIN; i++) taps[i] <= taps[i-1];
    end
  end

  // column memory: clearing pass, then read at accept, write at update
  always_ff @(posedge clk) begin
    if (fstate == F_CLEAR) col_mem[clr_cnt] <= '0;
    else if (fstate == F_UPD && col_in) col_mem[cur_col[COL_W-1:0]] <= cs_new;
    if (accept) col_rd <= col_mem[eff_col[COL_W-1:0]];
  end

  // row store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (fstate == F_UPD && col_in && row_in)
      row_mem[RS_AW'({cur_row[3:0], cur_col[COL_W-1:0]})] <= cur_pix;
    if (accept) begin
      old_rd <= row_mem[RS_AW'({eff_row[3:0], eff_col[COL_W-1:0]})];
      ctr_rd <= row_mem[RS_AW'({cy_e[3:0], cx_e[COL_W-1:0]})];
    end
  end

endmodule

// ===== rtl/lvss_back.sv =====
module lvss_back import lvss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      noise_variance,
  input  lvss_qstat_t      qstat,
  input  lvss_job_t        job_in,
  output logic             job_pop,
  input  logic             pop,
  output logic             empty,
  output logic [COL_W-1:0] pixel_x,
  output logic [COL_W-1:0] pixel_y,
  output logic [7:0]       smooth_blue,
  output logic [7:0]       smooth_green,
  output logic [7:0]       smooth_red,
  output logic             skin,
  output logic             last_of_frame
);

  back_state_t bstate, bstate_next;

  lvss_job_t        job;
  logic [1:0]       ch;
  logic [31:0]      sq, t;
  logic [15:0]      mean;
  logic [23:0]      dvn;
  logic [24:0]      numnv;
  logic [25:0]      den;
  logic [16:0]      g;
  logic [32:0]      p1;
  logic [24:0]      p2;
  logic [2:0][7:0]  res;
  logic             out_valid;

  logic               div_start, div_done, out_load;
  logic [DIV_N_W-1:0] div_num, div_q;
  logic [DIV_D_W-1:0] div_den;
  logic [33:0]        blend;
  logic [17:0]        v;
  logic [16:0]        one_m_g;

  lvss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (bstate)
      B_IDLE:   bstate_next = qstat.empty ? B_IDLE : B_SQ;
      B_SQ:     bstate_next = B_T_GO;
      B_T_GO:   bstate_next = B_T_WAIT;
      B_T_WAIT: bstate_next = div_done ? B_M_GO : B_T_WAIT;
      B_M_GO:   bstate_next = B_M_WAIT;
      B_M_WAIT: bstate_next = div_done ? B_DEN : B_M_WAIT;
      B_DEN:    bstate_next = B_G_GO;
      B_G_GO:   bstate_next = (den == '0) ? B_MUL : B_G_WAIT;
      B_G_WAIT: bstate_next = div_done ? B_MUL : B_G_WAIT;
      B_MUL:    bstate_next = B_SUM;
      B_SUM:    bstate_next = (ch == 2'd2) ? B_OUT : B_SQ;
      B_OUT:    bstate_next = (!out_valid || pop) ? B_IDLE : B_OUT;
      default:  bstate_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = (bstate == B_IDLE) && !qstat.empty;
    out_load  = (bstate == B_OUT) && (!out_valid || pop);
    div_start = 1'b0;
    div_num   = {8'd0, sq};
    div_den   = DIV_D_W'(job.num);
    case (bstate)
      B_T_GO: begin
        div_start = 1'b1;
      end
      B_M_GO: begin
        div_start = 1'b1;
        div_num   = DIV_N_W'(job.s[ch]);
      end
      B_G_GO: begin
        div_start = den != '0;
        div_num   = {dvn, 16'd0};
        div_den   = den;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    one_m_g = 17'h10000 - g;
    blend   = {1'b0, p1} + 34'(p2);
    v       = blend[33:GAIN_FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      bstate <= bstate_next;
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // datapath, one channel at a time
  always_ff @(posedge clk) begin
    case (bstate)
      B_IDLE: begin
        job <= job_in;
        ch  <= '0;
      end
      B_SQ:     sq <= job.s[ch] * job.s[ch];
      B_T_WAIT: if (div_done) t <= div_q[31:0];
      B_M_WAIT: begin
        if (div_done) begin
          mean  <= div_q[15:0];
          dvn   <= ({8'd0, job.q[ch]} > t) ? job.q[ch] - t[23:0] : '0;
          numnv <= job.num * noise_variance;
        end
      end
      B_DEN:    den <= {2'd0, dvn} + {1'b0, numnv};
      B_G_GO:   g <= '0;
      B_G_WAIT: if (div_done) g <= div_q[16:0];
      B_MUL: begin
        p1 <= one_m_g * mean;
        p2 <= g * job.pix[ch];
      end
      B_SUM: begin
        res[ch] <= (v > 18'd255) ? 8'd255 : v[7:0];
        ch      <= ch + 1'b1;
      end
      default: begin
        ch <= ch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_x       <= job.cx;
      pixel_y       <= job.cy;
      smooth_blue   <= res[0];
      smooth_green  <= res[1];
      smooth_red    <= res[2];
      skin          <= job.skin;
      last_of_frame <= job.last;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== rtl/local_variance_skin_smoothing_unit.sv =====
// channel   direction  handshake                    payload
// input     in         push / full                  first_of_frame, blue, green, red, luma,
//                                                   chroma_red, chroma_blue
// result    out        empty / pop                  pixel_x, pixel_y, smooth_blue, smooth_green,
//                                                   smooth_red, skin, last_of_frame
// config    in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// the front takes no new item until the last one's update is done, nor while the job queue is full:
// registered row store and column reads, then update; the back works on one result at a time,
// 3 channels, each 3 passes through the shared restoring divider plus square and blend, then
// waits for the output register to be free (a zero gain denominator skips the third pass)
// reset is synchronous; then a clearing pass over all 1024 column memory entries holds full high
// a 4-deep job queue and the output register let each side stall on its own
module local_variance_skin_smoothing_unit import lvss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        first_of_frame,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic [7:0]  luma,
  input  logic [7:0]  chroma_red,
  input  logic [7:0]  chroma_blue,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  pixel_x,
  output logic [9:0]  pixel_y,
  output logic [7:0]  smooth_blue,
  output logic [7:0]  smooth_green,
  output logic [7:0]  smooth_red,
  output logic        skin,
  output logic        last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [POS_W-1:0] image_width;
  logic [POS_W-1:0] image_height;
  logic [15:0]      noise_variance;

  // front to back queue
  lvss_job_t   job_wr, job_rd;
  logic        job_push, job_pop;
  lvss_qstat_t qstat;

  // config beats never stall; index 3 is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= POS_W'(640);
      image_height   <= POS_W'(480);
      noise_variance <= 16'd400;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[POS_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[POS_W-1:0];
        REG_NOISE_VARIANCE: noise_variance <= cfg_data;
        default:            noise_variance <= noise_variance;
      endcase
    end
  end

  // front: position counters, row store, column sums, window sums
  lvss_front u_front (
    .clk            (clk),
    .rst            (rst),
    .image_width    (image_width),
    .image_height   (image_height),
    .push           (push),
    .full           (full),
    .first_of_frame (first_of_frame),
    .blue           (blue),
    .green          (green),
    .red            (red),
    .luma           (luma),
    .chroma_red     (chroma_red),
    .chroma_blue    (chroma_blue),
    .qstat          (qstat),
    .job_push       (job_push),
    .job            (job_wr)
  );

  // short queue of finished windows waiting for the arithmetic
  lvss_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (job_wr),
    .rd     (job_pop),
    .rd_job (job_rd),
    .qstat  (qstat)
  );

  // back: mean, variance, gain and blend per channel, then the output register
  lvss_back u_back (
    .clk            (clk),
    .rst            (rst),
    .noise_variance (noise_variance),
    .qstat          (qstat),
    .job_in         (job_rd),
    .job_pop        (job_pop),
    .pop            (pop),
    .empty          (empty),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .smooth_blue    (smooth_blue),
    .smooth_green   (smooth_green),
    .smooth_red     (smooth_red),
    .skin           (skin),
    .last_of_frame  (last_of_frame)
  );

  // an accepted beat keeps the front busy for its update cycle
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full)
    else $error("front took a second beat during an update");

  // the job queue never claims to be both full and empty
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("job queue full and empty at once");

  // no push into a full job queue
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !qstat.full)
    else $error("job pushed into a full queue");

  // clearing pass holds the input off right after reset
  a_clear_hold: assert property (@(posedge clk)
    $fell(rst) |-> full)
    else $error("input open during the clearing pass");

endmodule

// ===== bench/local_variance_skin_smoothing_unit_tb.sv =====
`timescale 1ns / 1ps

module local_variance_skin_smoothing_unit_tb import lvss_pkg::*; ();

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 600;

  typedef struct {
    logic       first;
    logic [7:0] b, g, r, y, cr, cb;
    logic       drain;   // wait for all pending results before offering this one
  } pixel_beat_t;

  typedef struct {
    logic [9:0] x, y;
    logic [7:0] b, g, r;
    logic       skin, last;
  } smooth_px_t;

  logic        clk, rst;
  logic        push, full, first_of_frame;
  logic [7:0]  blue, green, red, luma, chroma_red, chroma_blue;
  logic        empty, pop;
  logic [9:0]  pixel_x, pixel_y;
  logic [7:0]  smooth_blue, smooth_green, smooth_red;
  logic        skin, last_of_frame;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  local_variance_skin_smoothing_unit u_dut (.*);

  // pending stimulus and the pixels we expect back
  pixel_beat_t pixel_q[$];
  smooth_px_t  smoothed_q[$];

  // shadow of the block's state
  logic [47:0] line_px  [0:WIN*MAX_DIM-1];
  logic [31:0] col_s    [0:MAX_DIM-1][0:2];
  logic [31:0] col_q    [0:MAX_DIM-1][0:2];
  logic [31:0] win_s    [0:2];
  logic [31:0] win_q    [0:2];
  int unsigned cur_row, cur_col;
  int unsigned img_w, img_h, noise_var;

  int errors, items_sent, results_seen, phases, cycles;
  int skin_hits, last_hits;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, smoothed_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 1) return 1;
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  function automatic logic [7:0] lee_channel(logic [31:0] s, logic [31:0] q, int unsigned num,
                                             logic [7:0] pix);
    longint unsigned one, t, dvn, den, g, mean, v;
    one  = 64'd1 << GAIN_FRAC;
    t    = (longint'(s) * longint'(s)) / num;
    dvn  = (longint'(q) > t) ? longint'(q) - t : 0;
    den  = dvn + longint'(num) * longint'(noise_var);
    g    = (den != 0) ? (dvn << GAIN_FRAC) / den : 0;
    mean = longint'(s) / num;
    v    = ((one - g) * mean + g * longint'(pix)) >> GAIN_FRAC;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // advance the shadow state by one accepted beat, queue the pixel it finishes
  task automatic step_filter(pixel_beat_t it);
    int unsigned w, h, row, col, slot, cy, cx, x1, x2, y1, y2, num;
    logic [47:0] old, px, centre;
    logic [31:0] cs, cq, ws, wq, o, n;
    smooth_px_t  res;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    if (it.first) begin
      cur_row = 0;
      cur_col = 0;
    end
    row = cur_row;
    col = cur_col;
    // column sums over the last 16 rows
    if (col < w) begin
      slot = (row % WIN) * MAX_DIM + col;
      old  = line_px[slot];
      px   = {it.cb, it.cr, it.y, it.r, it.g, it.b};
      for (int c = 0; c < 3; c++) begin
        cs = (row == 0) ? 32'd0 : col_s[col][c];
        cq = (row == 0) ? 32'd0 : col_q[col][c];
        if (row >= WIN) begin
          o  = old[8*c +: 8];
          cs = cs - o;
          cq = cq - o * o;
        end
        if (row < h) begin
          n  = px[8*c +: 8];
          cs = cs + n;
          cq = cq + n * n;
        end
        col_s[col][c] = cs & 32'hFFF;
        col_q[col][c] = cq & 32'hFFFFF;
      end
      if (row < h) line_px[slot] = px;
    end
    // sliding window across the columns
    for (int c = 0; c < 3; c++) begin
      ws = (col == 0) ? 32'd0 : win_s[c];
      wq = (col == 0) ? 32'd0 : win_q[c];
      if (col < w) begin
        ws = ws + col_s[col][c];
        wq = wq + col_q[col][c];
      end
      if (col >= WIN && col - WIN < w) begin
        ws = ws - col_s[col-WIN][c];
        wq = wq - col_q[col-WIN][c];
      end
      win_s[c] = ws & 32'hFFFF;
      win_q[c] = wq & 32'hFFFFFF;
    end
    // centre inside the image gives a result
    if (row >= RADIUS && col >= RADIUS && row - RADIUS < h && col - RADIUS < w) begin
      cy = row - RADIUS;
      cx = col - RADIUS;
      x2 = (col + 1 > w) ? w : col + 1;
      y2 = (row + 1 > h) ? h : row + 1;
      x1 = (col >= KERNEL) ? col - KERNEL : 0;
      y1 = (row >= KERNEL) ? row - KERNEL : 0;
      num = (x2 - x1) * (y2 - y1);
      centre = line_px[(cy % WIN) * MAX_DIM + cx];
      res.x = cx[9:0];
      res.y = cy[9:0];
      res.b = lee_channel(win_s[0], win_q[0], num, centre[7:0]);
      res.g = lee_channel(win_s[1], win_q[1], num, centre[15:8]);
      res.r = lee_channel(win_s[2], win_q[2], num, centre[23:16]);
      res.skin = (centre[31:24] > SKIN_Y_MIN && centre[47:40] > SKIN_CB_LO &&
                  centre[47:40] < SKIN_CB_HI && centre[39:32] > SKIN_CR_LO &&
                  centre[39:32] < SKIN_CR_HI);
      res.last = (cy == h - 1 && cx == w - 1);
      smoothed_q.push_back(res);
    end
    col++;
    if (col >= w + RADIUS) begin
      col = 0;
      row++;
      if (row >= h + RADIUS) row = 0;
    end
    cur_col = col & 11'h7FF;
    cur_row = row & 11'h7FF;
  endtask

  // mostly short gaps, some long ones, and quiet stretches with none at all
  logic no_idle_stretch;
  function automatic int idle_gap();
    int p;
    if (no_idle_stretch) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && $urandom_range(299) == 0) no_idle_stretch <= ~no_idle_stretch;
  end

  // driver: offers queued pixels, predicts on every accepted beat
  pixel_beat_t cur_beat;
  int          send_gap;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap <= 0;
    end else if (!push || !full) begin
      if (push) begin
        step_filter(cur_beat);
        items_sent++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (pixel_q.size() > 0 &&
                   !(pixel_q[0].drain && (smoothed_q.size() > 0 || push))) begin
        cur_beat = pixel_q.pop_front();
        first_of_frame <= cur_beat.first;
        blue <= cur_beat.b;
        green <= cur_beat.g;
        red <= cur_beat.r;
        luma <= cur_beat.y;
        chroma_red <= cur_beat.cr;
        chroma_blue <= cur_beat.cb;
        push <= 1'b1;
        send_gap <= idle_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: takes results and checks them against the oldest expected pixel
  int pop_gap, long_hold;
  logic hold_done;
  always @(posedge clk) begin
    smooth_px_t want;
    if (rst) begin
      pop <= 1'b0;
      pop_gap <= 0;
      long_hold <= 0;
      hold_done <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (skin) skin_hits++;
        if (last_of_frame) last_hits++;
        if (smoothed_q.size() == 0) begin
          report("unexpected result x", pixel_x, -1);
        end else begin
          want = smoothed_q.pop_front();
          if (pixel_x !== want.x) report("pixel_x", pixel_x, want.x);
          if (pixel_y !== want.y) report("pixel_y", pixel_y, want.y);
          if (smooth_blue !== want.b) report("smooth_blue", smooth_blue, want.b);
          if (smooth_green !== want.g) report("smooth_green", smooth_green, want.g);
          if (smooth_red !== want.r) report("smooth_red", smooth_red, want.r);
          if (skin !== want.skin) report("skin", skin, want.skin);
          if (last_of_frame !== want.last) report("last_of_frame", last_of_frame, want.last);
        end
      end
      // one long hold-off so the job queue fills and the input stalls
      if (!hold_done && results_seen == 60) begin
        hold_done <= 1'b1;
        long_hold <= 3000;
        pop <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        pop_gap <= idle_gap();
      end
    end
  end

  // register write while the block is idle, followed by a quiet wait with cfg_valid low
  task automatic write_reg(reg_index_t idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:    img_w = data & 16'h7FF;
      REG_IMAGE_HEIGHT:   img_h = data & 16'h7FF;
      REG_NOISE_VARIANCE: noise_var = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pixel_q.size() > 0 || push || smoothed_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(logic [15:0] w, logic [15:0] h, logic [15:0] nv);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_NOISE_VARIANCE, nv);
    @(posedge clk);
    phases++;
  endtask

  // queue one frame (or its first n beats); style 0 random, 1 flat, 2 extremes, 3 skin-like
  task automatic queue_frame(int w, int h, int n, int style, bit drain_mid);
    pixel_beat_t it;
    int total;
    logic [7:0] flat;
    total = (clamp_dim(h) + RADIUS) * (clamp_dim(w) + RADIUS);
    if (n > 0 && n < total) total = n;
    flat = $urandom_range(255);
    for (int i = 0; i < total; i++) begin
      it.first = (i == 0);
      it.drain = drain_mid && (i == total / 2);
      case (style)
        1: begin
          it.b = flat; it.g = flat; it.r = flat; it.y = flat; it.cr = flat; it.cb = flat;
        end
        2: begin
          it.b = $urandom_range(1) ? 8'hFF : 8'h00;
          it.g = $urandom_range(1) ? 8'hFF : 8'h00;
          it.r = $urandom_range(1) ? 8'hFF : 8'h00;
          it.y = $urandom_range(1) ? 8'hFF : 8'h00;
          it.cr = $urandom_range(1) ? 8'hFF : 8'h00;
          it.cb = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        3: begin
          it.b = $urandom_range(255); it.g = $urandom_range(255); it.r = $urandom_range(255);
          // hover around the skin thresholds
          it.y  = $urandom_range(78, 255);
          it.cb = $urandom_range(84, 136);
          it.cr = $urandom_range(134, 181);
        end
        default: begin
          it.b = $urandom_range(255); it.g = $urandom_range(255); it.r = $urandom_range(255);
          it.y = $urandom_range(255); it.cr = $urandom_range(255); it.cb = $urandom_range(255);
        end
      endcase
      pixel_q.push_back(it);
    end
  endtask

  initial begin
    int w, h, nv;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    first_of_frame = 1'b0;
    {blue, green, red, luma, chroma_red, chroma_blue} = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    no_idle_stretch = 1'b0;
    errors = 0; items_sent = 0; results_seen = 0; phases = 0; cycles = 0;
    skin_hits = 0; last_hits = 0;
    img_w = 640; img_h = 480; noise_var = 400;
    cur_row = 0; cur_col = 0;
    for (int i = 0; i < WIN * MAX_DIM; i++) line_px[i] = '0;
    for (int i = 0; i < MAX_DIM; i++)
      for (int c = 0; c < 3; c++) begin
        col_s[i][c] = '0;
        col_q[i][c] = '0;
      end
    for (int c = 0; c < 3; c++) begin
      win_s[c] = '0;
      win_q[c] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: single pixel image, flat with no noise gives a zero denominator
    set_geometry(1, 1, 0);
    queue_frame(1, 1, 0, 1, 0);
    queue_frame(1, 1, 0, 2, 0);
    set_geometry(2, 2, 16'hFFFF);
    queue_frame(2, 2, 0, 2, 0);
    queue_frame(2, 2, 0, 3, 0);
    // out of range sizes clamp to 1 and to the maximum; the maximum width, partly
    set_geometry(0, 16'hFFFF, 400);
    queue_frame(1, MAX_DIM, 300, 0, 0);
    set_geometry(MAX_DIM, 8, 1);
    queue_frame(MAX_DIM, 8, 400, 0, 0);

    // random phases of small images, a few tall enough to retire old rows
    while (items_sent + pixel_q.size() < 1400) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      h = ($urandom_range(5) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      case ($urandom_range(3))
        0: nv = 0;
        1: nv = 16'hFFFF;
        2: nv = $urandom_range(1, 800);
        default: nv = $urandom_range(65535);
      endcase
      set_geometry(w, h, nv);
      repeat ($urandom_range(1, 3)) begin
        // a cut-short frame now and then, restarted by the next first beat
        queue_frame(w, h, ($urandom_range(4) == 0) ? $urandom_range(1, 80) : 0,
                    ($urandom_range(4) == 0) ? $urandom_range(1, 2) :
                    ($urandom_range(2) == 0 ? 3 : 0),
                    $urandom_range(7) == 0);
      end
    end

    wait_idle();
    $display("sent %0d pixel beats over %0d geometry settings, checked %0d results",
             items_sent, phases, results_seen);
    $display("skin flags %0d, frame ends %0d, mismatches %0d", skin_hits, last_hits, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
